// ===== hdl/aes_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aes_pkg
// Shared constants, types and byte-level functions for the AES block cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int KEY_ENTRIES = 15;
  localparam int IDX_W       = $clog2(KEY_ENTRIES);
  localparam int BLK_W       = 128;

  // highest round count the key store supports
  localparam logic [3:0] MAX_ROUNDS   = 4'(KEY_ENTRIES - 1);
  localparam logic [3:0] MIN_ROUNDS   = 4'd1;
  localparam logic [3:0] ROUNDS_RESET = 4'd10;

  localparam logic [7:0] XTIME_POLY = 8'h1b;

  typedef logic [BLK_W-1:0] blk_t;

  // round control passed to the round datapath
  typedef struct packed {
    logic first;  // initial key whitening only
    logic last;   // final round, no column mix
  } round_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
    8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
    8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
    8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
    8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
    8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
    8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
    8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
    8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
    8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
    8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
    8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
    8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
    8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
    8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
    8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
    8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? XTIME_POLY : 8'h00);
  endfunction

  // byte i of the block, byte 0 in the top bits
  function automatic logic [7:0] get_byte(input blk_t b, input int i);
    return b[BLK_W-1-8*i -: 8];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/aes_block_encrypt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aes_block_encrypt
// AES-128/192/256 block encryption over a preloaded round key schedule.
// ----------------------------------------------------------------------------
// Requests with mode 0 write one 128-bit round key into entry round_index of
// a 15-entry key RAM (indices above 14 are ignored) and give no result.
// Requests with mode 1 encrypt data_hi/data_lo and return one ciphertext.
// An encryption runs one round per cycle on a shared round unit, fetching
// the round keys from the key RAM one per cycle. It accepts the request,
// fetches key 0, runs R + 1 round steps (R = num_rounds, clamped to 1..14)
// and hands the result to the output register, waiting while that register
// holds an unread ciphertext. A result waits there while the next request
// is taken. num_rounds is written through cfg_we/cfg_data; the user must
// do so only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module aes_block_encrypt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        mode,
  input  wire logic [3:0]  round_index,
  input  wire logic [63:0] data_hi,
  input  wire logic [63:0] data_lo,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [63:0] cipher_hi,
  output      logic [63:0] cipher_lo
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_ENC  = 1'b1;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [3:0]    num_rounds;
  logic [3:0]    rounds;
  logic [3:0]    rnd;
  aes_pkg::blk_t blk;
  aes_pkg::blk_t key;
  aes_pkg::blk_t round_res;
  aes_pkg::round_ctl_t ctl;

  logic                      accept;
  logic                      accept_enc;
  logic                      key_we;
  logic                      key_re;
  logic [aes_pkg::IDX_W-1:0] key_raddr;
  logic                      last_step;
  logic                      out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rounds <= aes_pkg::ROUNDS_RESET;
    end else if (cfg_we) begin
      num_rounds <= cfg_data;
    end
  end

  always_comb begin
    if (num_rounds < aes_pkg::MIN_ROUNDS) begin
      rounds = aes_pkg::MIN_ROUNDS;
    end else if (num_rounds > aes_pkg::MAX_ROUNDS) begin
      rounds = aes_pkg::MAX_ROUNDS;
    end else begin
      rounds = num_rounds;
    end
  end

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign accept_enc = accept && (mode == MODE_ENC);
  assign key_we     = accept && (mode == MODE_LOAD) && (round_index <= aes_pkg::MAX_ROUNDS);
  assign last_step  = (state == ST_RUN) && (rnd == rounds);
  assign out_free   = !out_valid || out_ready;

  // fetch key 0 on accept, then the key for the following step each cycle
  assign key_re    = accept_enc || ((state == ST_RUN) && !last_step);
  assign key_raddr = accept_enc ? '0 : aes_pkg::IDX_W'(rnd + 4'd1);

  aes_key_ram #(
    .DEPTH (aes_pkg::KEY_ENTRIES),
    .WIDTH (aes_pkg::BLK_W),
    .AW    (aes_pkg::IDX_W)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (round_index[aes_pkg::IDX_W-1:0]),
    .wdata ({data_hi, data_lo}),
    .re    (key_re),
    .raddr (key_raddr),
    .rdata (key)
  );

  assign ctl.first = (rnd == 4'd0);
  assign ctl.last  = (rnd == rounds);

  aes_round u_round (
    .blk    (blk),
    .key    (key),
    .ctl    (ctl),
    .result (round_res)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept_enc) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_step) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_enc) begin
      blk <= {data_hi, data_lo};
      rnd <= 4'd0;
    end else if (state == ST_RUN) begin
      blk <= round_res;
      rnd <= rnd + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      cipher_hi <= blk[127:64];
      cipher_lo <= blk[63:0];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/aes_key_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aes_key_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module aes_key_ram #(
  parameter int DEPTH = 15,
  parameter int WIDTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/aes_round.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aes_round
// One cipher round: SubBytes, ShiftRows, MixColumns (skipped in the last
// round), AddRoundKey, or the initial key addition alone.
// ----------------------------------------------------------------------------
module aes_round (
  input  wire aes_pkg::blk_t      blk,
  input  wire aes_pkg::blk_t      key,
  input  wire aes_pkg::round_ctl_t ctl,
  output      aes_pkg::blk_t      result
);

  logic [7:0] ss [16];
  logic [7:0] mc [16];
  aes_pkg::blk_t round_out;

  // SubBytes + ShiftRows: row r of column c comes from column (c+r) mod 4
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        ss[c*4+r] = aes_pkg::SBOX[aes_pkg::get_byte(blk, ((c + r) % 4) * 4 + r)];
      end
    end
  end

  always_comb begin
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0  = ss[c*4];
      a1  = ss[c*4+1];
      a2  = ss[c*4+2];
      a3  = ss[c*4+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (ctl.last) begin
        mc[c*4]   = a0;
        mc[c*4+1] = a1;
        mc[c*4+2] = a2;
        mc[c*4+3] = a3;
      end else begin
        mc[c*4]   = a0 ^ all ^ aes_pkg::xtime(a0 ^ a1);
        mc[c*4+1] = a1 ^ all ^ aes_pkg::xtime(a1 ^ a2);
        mc[c*4+2] = a2 ^ all ^ aes_pkg::xtime(a2 ^ a3);
        mc[c*4+3] = a3 ^ all ^ aes_pkg::xtime(a3 ^ a0);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      round_out[aes_pkg::BLK_W-1-8*i -: 8] = mc[i];
    end
  end

  assign result = (ctl.first ? blk : round_out) ^ key;

endmodule
`default_nettype wire

// ===== hdl/aes_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aes_chk
// Port-level checks for aes_block_encrypt, bound to the top level.
// ----------------------------------------------------------------------------
module aes_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        mode,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] cipher_hi,
  input wire logic [63:0] cipher_lo
);

  logic load_req;
  logic enc_req;

  assign load_req = in_valid && in_ready && !mode;
  assign enc_req  = in_valid && in_ready && mode;

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cipher_hi) && $stable(cipher_lo))
    else $error("stalled result changed");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    load_req && !out_valid |=> !out_valid)
    else $error("key load produced a result");

  a_busy_after_enc: assert property (@(posedge clk) disable iff (rst)
    enc_req |=> !in_ready)
    else $error("request taken while encrypting");

  a_enc_latency: assert property (@(posedge clk) disable iff (rst)
    enc_req && !out_valid |=> !out_valid ##1 !out_valid)
    else $error("ciphertext too early");

endmodule

bind aes_block_encrypt aes_chk u_aes_chk (.*);
`default_nettype wire
